@@ design/pat_pkg.sv @@
// ----------------------------------------------------------------------------
// pat_pkg
// Shared constants, status codes and types of the paged address translator.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int OFF_BITS    = 8;    // page offset bits
  localparam int LOG_PAGES   = 4;    // logical pages in the table
  localparam int PHYS_FRAMES = 8;    // physical frames to hand out

  localparam int ADDR_W   = 16;
  localparam int RIGHTS_W = 3;
  localparam int STATUS_W = 3;
  localparam int PA_W     = 11;

  localparam int PAGE_W  = ADDR_W - OFF_BITS;
  localparam int IDX_W   = (LOG_PAGES > 1) ? $clog2(LOG_PAGES) : 1;
  localparam int FRAME_W = $clog2(PHYS_FRAMES + 1);   // holds PHYS_FRAMES itself

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDS  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ACCESS  = 3'd4;

  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  typedef struct packed {
    logic [RIGHTS_W-1:0] rights;
    logic [FRAME_W-1:0]  frame;
  } entry_t;

  // Table access issued in one cycle: at most one write or one read.
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] idx;
    entry_t           wdata;
  } tbl_req_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } tbl_rsp_t;

endpackage

@@ design/pat_table.sv @@
// ----------------------------------------------------------------------------
// pat_table
// Page table storage: synchronous entry memory with registered read, plus
// per-entry valid flops cleared at reset.
// ----------------------------------------------------------------------------
module pat_table (
  input  logic               clk,
  input  logic               rst_n,
  input  pat_pkg::tbl_req_t  req,
  output pat_pkg::tbl_rsp_t  rsp
);

  pat_pkg::entry_t                  mem [pat_pkg::LOG_PAGES];
  logic [pat_pkg::LOG_PAGES-1:0]    valid_r;
  logic [pat_pkg::LOG_PAGES-1:0]    valid_nxt;
  pat_pkg::tbl_rsp_t                rsp_r;

  always_comb begin
    valid_nxt = valid_r;
    if (req.we) begin
      valid_nxt[req.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.idx] <= req.wdata;
    end
    if (req.re) begin
      rsp_r.entry <= mem[req.idx];
      rsp_r.valid <= valid_r[req.idx];
    end
  end

  assign rsp = rsp_r;

endmodule

@@ design/paged_address_translator.sv @@
// ----------------------------------------------------------------------------
// paged_address_translator
// Single-level page table with a bump frame allocator: map and translate.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input is registered into stage 1 together with the table
//   read, then into the output register once that register is empty or taken.
// Throughput: one transaction per cycle while out_tready does not stall; set by
//   the single table port, which takes the map write or translate read at accept.
// Reset: synchronous, active low; clears the entry valid flops, the frame
//   allocator and the pipeline valids. No clearing pass; input ready at once.
// ----------------------------------------------------------------------------
module paged_address_translator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] vaddr, [18:16] rights, rest zero
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [10:0] paddr, rest zero
  output logic [2:0]  out_tuser   // [2:0] status
);

  // --------------------------------------------------------------------------
  // Input field unpack
  // --------------------------------------------------------------------------
  logic                             cmd;
  logic [pat_pkg::ADDR_W-1:0]       addr;
  logic [pat_pkg::RIGHTS_W-1:0]     rights;
  logic [pat_pkg::PAGE_W-1:0]       page;
  logic [pat_pkg::IDX_W-1:0]        idx;
  logic [pat_pkg::OFF_BITS-1:0]     offset;
  logic                             in_bounds;
  logic                             full;
  logic                             in_acc;

  assign cmd    = in_tuser[0];
  assign addr   = in_tdata[15:0];
  assign rights = in_tdata[18:16];
  assign page   = addr[pat_pkg::ADDR_W-1:pat_pkg::OFF_BITS];
  assign offset = addr[pat_pkg::OFF_BITS-1:0];
  // page is compared one bit wider so the page count itself fits
  assign in_bounds = {1'b0, page} < (pat_pkg::PAGE_W+1)'(pat_pkg::LOG_PAGES);
  assign idx       = pat_pkg::IDX_W'(page);

  // --------------------------------------------------------------------------
  // Frame allocator. Map is resolved entirely at accept: bounds and full are
  // known from the address and the allocator, so the table write happens on
  // the accept edge and a following translate always reads updated data.
  // --------------------------------------------------------------------------
  logic [pat_pkg::FRAME_W-1:0] next_free_r;
  logic [pat_pkg::FRAME_W-1:0] next_free_nxt;
  logic                        map_ok;

  assign full   = next_free_r >= pat_pkg::FRAME_W'(pat_pkg::PHYS_FRAMES);
  assign in_acc = in_tvalid && in_tready;
  assign map_ok = in_acc && (cmd == pat_pkg::CMD_MAP) && in_bounds && !full;

  always_comb begin
    next_free_nxt = next_free_r;
    if (map_ok) begin
      next_free_nxt = next_free_r + pat_pkg::FRAME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= '0;
    end else begin
      next_free_r <= next_free_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Table access
  // --------------------------------------------------------------------------
  pat_pkg::tbl_req_t tbl_req;
  pat_pkg::tbl_rsp_t tbl_rsp;

  always_comb begin
    tbl_req              = '0;
    tbl_req.idx          = idx;
    tbl_req.we           = map_ok;
    tbl_req.wdata.rights = rights;
    tbl_req.wdata.frame  = next_free_r;
    // read only on accepted translates so the read register holds across stalls
    tbl_req.re           = in_acc && (cmd == pat_pkg::CMD_XLATE) && in_bounds;
  end

  pat_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  // --------------------------------------------------------------------------
  // Stage 1: early status and map frame, waiting for the table read
  // --------------------------------------------------------------------------
  logic                            s1_v_r,      s1_v_nxt;
  logic                            s1_cmd_r;
  logic [pat_pkg::STATUS_W-1:0]    s1_st_r;
  logic [pat_pkg::FRAME_W-1:0]     s1_frame_r;
  logic [pat_pkg::OFF_BITS-1:0]    s1_off_r;
  logic [pat_pkg::RIGHTS_W-1:0]    s1_rights_r;
  logic [pat_pkg::STATUS_W-1:0]    pre_st;
  logic                            s1_adv;

  always_comb begin
    if (!in_bounds) begin
      pre_st = pat_pkg::ST_BOUNDS;
    end else if ((cmd == pat_pkg::CMD_MAP) && full) begin
      pre_st = pat_pkg::ST_FULL;
    end else begin
      pre_st = pat_pkg::ST_OK;
    end
  end

  assign s1_adv    = s1_v_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_v_r || s1_adv;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= cmd;
      s1_st_r     <= pre_st;
      s1_frame_r  <= next_free_r;
      s1_off_r    <= offset;
      s1_rights_r <= rights;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 resolve: translate checks validity, then rights subset
  // --------------------------------------------------------------------------
  logic [pat_pkg::STATUS_W-1:0]                st_fin;
  logic [pat_pkg::PA_W-1:0]                    pa_fin;
  logic [pat_pkg::FRAME_W+pat_pkg::OFF_BITS-1:0] pa_full;

  always_comb begin
    st_fin  = s1_st_r;
    pa_full = '0;
    if (s1_st_r == pat_pkg::ST_OK) begin
      if (s1_cmd_r == pat_pkg::CMD_MAP) begin
        pa_full = {s1_frame_r, {pat_pkg::OFF_BITS{1'b0}}};
      end else if (!tbl_rsp.valid) begin
        st_fin = pat_pkg::ST_INVALID;
      end else if ((s1_rights_r & tbl_rsp.entry.rights) != s1_rights_r) begin
        st_fin = pat_pkg::ST_ACCESS;
      end else begin
        // offset is below one page, so base plus offset is a concatenation
        pa_full = {tbl_rsp.entry.frame, s1_off_r};
      end
    end
    pa_fin = pat_pkg::PA_W'(pa_full);
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                         out_v_r, out_v_nxt;
  logic [pat_pkg::STATUS_W-1:0] out_st_r;
  logic [pat_pkg::PA_W-1:0]     out_pa_r;

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_st_r <= st_fin;
      out_pa_r <= pa_fin;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {{(16-pat_pkg::PA_W){1'b0}}, out_pa_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_err_pa_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != pat_pkg::ST_OK) |-> (out_tdata == '0))
    else $error("nonzero physical address on error status");

  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= pat_pkg::FRAME_W'(pat_pkg::PHYS_FRAMES))
    else $error("frame allocator beyond frame count");

  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    map_ok |=> (next_free_r == $past(next_free_r) + pat_pkg::FRAME_W'(1)))
    else $error("allocator did not advance on successful map");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted transaction lost before stage 1");

endmodule
